FILE: rtl/fbf_pkg.sv
// fbf_pkg: shared constants and codes of the block floating point codec
// no dependencies
`default_nettype none

package fbf_pkg;

    // action codes
    localparam logic [1:0] ACT_SPLIT   = 2'd0;
    localparam logic [1:0] ACT_ALIGN   = 2'd1;
    localparam logic [1:0] ACT_REGEN   = 2'd2;

    // fixed shift offsets of the sum format
    localparam int PRE_SHIFT  = 6;
    localparam int POST_SHIFT = 17;

    // word geometry
    localparam int WORD_W     = 96;
    localparam int POS_W      = 7;
    localparam int EXP_W      = 11;
    localparam int FRAC_W     = 52;
    localparam int MAN_W      = 54;

    localparam logic [EXP_W-1:0] EXP_ALL_ONES = 11'h7ff;
    localparam logic [63:0]      QNAN_BITS    = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0]      INF_BITS     = 64'h7FF0_0000_0000_0000;

    typedef logic [WORD_W-1:0] word96_t;

endpackage

`default_nettype wire

FILE: rtl/fbf_if.sv
// fbf_req_if, fbf_rsp_if: valid/ready channels of the codec
// depends on fbf_pkg
`default_nettype none

interface fbf_req_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            action;
    logic [63:0]           value_bits;
    logic [10:0]           exponent;
    logic [10:0]           max_exponent;
    logic signed [53:0]    split_mantissa;
    logic signed [31:0]    sum_hi;
    logic [63:0]           sum_lo;

    modport source (
        output valid, action, value_bits, exponent, max_exponent,
               split_mantissa, sum_hi, sum_lo,
        input  ready
    );
    modport sink (
        input  valid, action, value_bits, exponent, max_exponent,
               split_mantissa, sum_hi, sum_lo,
        output ready
    );
endinterface

interface fbf_rsp_if;
    logic                  valid;
    logic                  ready;
    logic [10:0]           out_exponent;
    logic signed [53:0]    out_mantissa;
    logic signed [31:0]    aligned_hi;
    logic [63:0]           aligned_lo;
    logic [63:0]           double_bits;

    modport source (
        output valid, out_exponent, out_mantissa, aligned_hi, aligned_lo,
               double_bits,
        input  ready
    );
    modport sink (
        input  valid, out_exponent, out_mantissa, aligned_hi, aligned_lo,
               double_bits,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/fbf_lzc96.sv
// fbf_lzc96: leading-one position of a 96-bit word, two-level encoder
// depends on fbf_pkg
`default_nettype none

module fbf_lzc96 (
    input  wire fbf_pkg::word96_t           word,
    output logic [fbf_pkg::POS_W-1:0]       pos
);

    localparam int GRP_N = fbf_pkg::WORD_W / 8;

    logic [GRP_N-1:0] grp_any;
    logic [2:0]       grp_pos [GRP_N];

    // position of the highest set bit inside each byte
    always_comb
    begin
        for (int g = 0; g < GRP_N; g++)
        begin
            grp_any[g] = |word[g*8 +: 8];
            grp_pos[g] = 3'd0;
            for (int b = 0; b < 8; b++)
            begin
                if (word[g*8 + b])
                begin
                    grp_pos[g] = 3'(b);
                end
            end
        end
    end

    // highest nonzero byte wins
    always_comb
    begin
        pos = '0;
        for (int g = 0; g < GRP_N; g++)
        begin
            if (grp_any[g])
            begin
                pos = fbf_pkg::POS_W'(g * 8) + {4'b0, grp_pos[g]};
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fp64_block_float_codec_unit.sv
// fp64_block_float_codec_unit: split, align and regenerate for integer sums
// one item per cycle sustained while the output is not held;
// the three register stages are decode/negate, shift/leading-one, normalize.
// a stalled output holds the whole pipeline, nothing is dropped or repeated.
// reset clears the stage valid bits only; the data registers are not reset.
// depends on fbf_pkg, fbf_if, fbf_lzc96
`default_nettype none

module fp64_block_float_codec_unit (
    input  wire       clk,
    input  wire       rst_n,
    fbf_req_if.sink   request,
    fbf_rsp_if.source response
);

    localparam int EW = fbf_pkg::EXP_W;
    localparam int PW = fbf_pkg::POS_W;

    logic advance;

    // stage 1 registers
    logic                 s1_valid_reg;
    logic [1:0]           s1_act_reg;
    logic [EW-1:0]        s1_split_exp_reg;
    logic [53:0]          s1_split_man_reg;
    logic [53:0]          s1_sm_reg;
    logic [PW-1:0]        s1_shift_reg;
    logic                 s1_clear_reg;
    fbf_pkg::word96_t     s1_mag_reg;
    logic                 s1_sign_reg;
    logic                 s1_zero_reg;
    logic [EW-1:0]        s1_ex_reg;

    // stage 2 registers
    logic                 s2_valid_reg;
    logic [1:0]           s2_act_reg;
    logic [EW-1:0]        s2_split_exp_reg;
    logic [53:0]          s2_split_man_reg;
    fbf_pkg::word96_t     s2_aligned_reg;
    fbf_pkg::word96_t     s2_mag_reg;
    logic                 s2_sign_reg;
    logic                 s2_zero_reg;
    logic [EW-1:0]        s2_ex_reg;
    logic [PW-1:0]        s2_pos_reg;
    logic signed [12:0]   s2_dsub_reg;

    // stage 3 (output) registers
    logic                 s3_valid_reg;
    logic [EW-1:0]        s3_exp_reg;
    logic [53:0]          s3_man_reg;
    fbf_pkg::word96_t     s3_aligned_reg;
    logic [63:0]          s3_double_reg;

    // whole pipeline moves unless the output item is held
    assign advance       = !s3_valid_reg || response.ready;
    assign request.ready = advance;

    // ---------------- stage 1: split, align count, sum magnitude ----------------
    logic [EW-1:0]        s1_split_exp_next;
    logic [53:0]          s1_split_man_next;
    logic signed [12:0]   s1_d;
    fbf_pkg::word96_t     s1_sum;
    fbf_pkg::word96_t     s1_mag_next;

    always_comb
    begin
        s1_split_exp_next = request.value_bits[62:52];
        s1_split_man_next = {1'b0, (s1_split_exp_next != '0), request.value_bits[51:0]};
        if (request.value_bits[63])
        begin
            s1_split_man_next = 54'(0) - s1_split_man_next;
        end

        s1_d = $signed({2'b0, request.max_exponent}) + 13'(fbf_pkg::PRE_SHIFT)
               - $signed({2'b0, request.exponent});

        s1_sum = {request.sum_hi, request.sum_lo};
        s1_mag_next = s1_sum[95] ? (~s1_sum + 96'd1) : s1_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_act_reg       <= request.action;
            s1_split_exp_reg <= s1_split_exp_next;
            s1_split_man_reg <= s1_split_man_next;
            s1_sm_reg        <= request.split_mantissa;
            s1_shift_reg     <= s1_d[PW-1:0];
            s1_clear_reg     <= (s1_d < 13'sd0) || (s1_d >= 13'sd96);
            s1_mag_reg       <= s1_mag_next;
            s1_sign_reg      <= s1_sum[95];
            s1_zero_reg      <= (s1_sum == '0);
            s1_ex_reg        <= request.max_exponent;
        end
    end

    // ---------------- stage 2: align shift, leading one ----------------
    logic [PW-1:0]        s2_pos_next;
    fbf_pkg::word96_t     s2_aligned_next;
    logic signed [95:0]   s2_placed;
    logic signed [12:0]   s2_dsub_next;

    fbf_lzc96 u_lzc (
        .word (s1_mag_reg),
        .pos  (s2_pos_next)
    );

    always_comb
    begin
        s2_placed       = $signed({{10{s1_sm_reg[53]}}, s1_sm_reg, 32'b0});
        s2_aligned_next = s1_clear_reg ? '0 : fbf_pkg::word96_t'(s2_placed >>> s1_shift_reg);
        s2_dsub_next    = $signed({2'b0, s1_ex_reg}) + 13'(fbf_pkg::PRE_SHIFT)
                          - $signed({12'b0, (s1_ex_reg != '0)}) - 13'sd32;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_act_reg       <= s1_act_reg;
            s2_split_exp_reg <= s1_split_exp_reg;
            s2_split_man_reg <= s1_split_man_reg;
            s2_aligned_reg   <= s2_aligned_next;
            s2_mag_reg       <= s1_mag_reg;
            s2_sign_reg      <= s1_sign_reg;
            s2_zero_reg      <= s1_zero_reg;
            s2_ex_reg        <= s1_ex_reg;
            s2_pos_reg       <= s2_pos_next;
            s2_dsub_reg      <= s2_dsub_next;
        end
    end

    // ---------------- stage 3: normalize, special cases, output ----------------
    logic signed [12:0]   s3_nx;
    fbf_pkg::word96_t     s3_norm;
    fbf_pkg::word96_t     s3_sub;
    logic [12:0]          s3_neg_dsub;
    logic [63:0]          s3_double_next;
    logic [EW-1:0]        s3_exp_next;
    logic [53:0]          s3_man_next;
    fbf_pkg::word96_t     s3_aligned_next;

    always_comb
    begin
        s3_nx = $signed({2'b0, s2_ex_reg}) + 13'(fbf_pkg::POST_SHIFT)
                + $signed({6'b0, s2_pos_reg}) - 13'sd95;

        // leading one moved to bit 95, fraction follows it
        s3_norm = s2_mag_reg << (7'd95 - s2_pos_reg);

        // subnormal: shift of the unnormalized magnitude
        s3_neg_dsub = 13'(0) - s2_dsub_reg;
        if (s2_dsub_reg >= 13'sd0)
        begin
            s3_sub = s2_mag_reg << s2_dsub_reg;
        end
        else
        begin
            s3_sub = s2_mag_reg >> s3_neg_dsub;
        end

        if (s2_zero_reg)
        begin
            s3_double_next = '0;
        end
        else if (s2_ex_reg == fbf_pkg::EXP_ALL_ONES)
        begin
            s3_double_next = fbf_pkg::QNAN_BITS;
        end
        else if (s3_nx >= 13'sd2047)
        begin
            s3_double_next = fbf_pkg::INF_BITS;
        end
        else if (s3_nx < 13'sd1)
        begin
            s3_double_next = {s2_sign_reg, 11'b0, s3_sub[51:0]};
        end
        else
        begin
            s3_double_next = {s2_sign_reg, s3_nx[10:0], s3_norm[94:43]};
        end

        s3_exp_next     = '0;
        s3_man_next     = '0;
        s3_aligned_next = '0;
        case (s2_act_reg)
            fbf_pkg::ACT_SPLIT:
            begin
                s3_exp_next    = s2_split_exp_reg;
                s3_man_next    = s2_split_man_reg;
                s3_double_next = '0;
            end
            fbf_pkg::ACT_ALIGN:
            begin
                s3_aligned_next = s2_aligned_reg;
                s3_double_next  = '0;
            end
            fbf_pkg::ACT_REGEN:
            begin
            end
            default:
            begin
                s3_double_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_exp_reg     <= s3_exp_next;
            s3_man_reg     <= s3_man_next;
            s3_aligned_reg <= s3_aligned_next;
            s3_double_reg  <= s3_double_next;
        end
    end

    // result channel
    assign response.valid        = s3_valid_reg;
    assign response.out_exponent = s3_exp_reg;
    assign response.out_mantissa = $signed(s3_man_reg);
    assign response.aligned_hi   = $signed(s3_aligned_reg[95:64]);
    assign response.aligned_lo   = s3_aligned_reg[63:0];
    assign response.double_bits  = s3_double_reg;

endmodule

`default_nettype wire

FILE: tb/fbf_codec_check_pkg.sv
// fbf_codec_check_pkg: item types and the result scoreboard of the codec testbench
// holds its own bit-exact prediction of split, align and regenerate
// depends on fbf_pkg
`default_nettype none

package fbf_codec_check_pkg;

    import fbf_pkg::*;

    // the fourth action code does nothing and returns an all-zero result
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [63:0]        value_bits;
        logic [10:0]        exponent;
        logic [10:0]        max_exponent;
        logic signed [53:0] split_mantissa;
        logic signed [31:0] sum_hi;
        logic [63:0]        sum_lo;
    } codec_op_t;

    typedef struct packed {
        logic [10:0]        out_exponent;
        logic signed [53:0] out_mantissa;
        logic signed [31:0] aligned_hi;
        logic [63:0]        aligned_lo;
        logic [63:0]        double_bits;
    } codec_word_t;

    class codec_result_book;
        codec_word_t expected_words[$];
        int          mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // bit-exact result of one item
        function codec_word_t compute_codec_result(codec_op_t op);
            codec_word_t        r;
            logic [53:0]        mag;
            logic signed [95:0] placed;
            logic [95:0]        sum;
            logic               neg;
            int                 shift;
            int                 lead;
            int                 nexp;
            r = '0;
            case (op.action)
                ACT_SPLIT:
                begin
                    // hidden bit only for a nonzero exponent, two's complement for sign
                    mag = {1'b0, |op.value_bits[62:52], op.value_bits[51:0]};
                    if (op.value_bits[63])
                        mag = -mag;
                    r.out_exponent = op.value_bits[62:52];
                    r.out_mantissa = mag;
                end
                ACT_ALIGN:
                begin
                    // mantissa sits at bits 85..32, then shifts right arithmetically
                    placed = {{10{op.split_mantissa[53]}}, op.split_mantissa, 32'd0};
                    shift = int'(op.max_exponent) + PRE_SHIFT - int'(op.exponent);
                    if (shift >= 0 && shift < WORD_W)
                        placed = placed >>> shift;
                    else
                        placed = '0;
                    {r.aligned_hi, r.aligned_lo} = placed;
                end
                ACT_REGEN:
                begin
                    sum = {op.sum_hi, op.sum_lo};
                    if (sum != '0)
                    begin
                        neg = sum[95];
                        // the most negative sum stays 2^95 as a magnitude
                        if (neg)
                            sum = -sum;
                        lead = 0;
                        for (int b = 0; b < WORD_W; b++)
                            if (sum[b])
                                lead = b;
                        nexp = int'(op.max_exponent) + POST_SHIFT + lead - 95;
                        if (op.max_exponent == EXP_ALL_ONES)
                            r.double_bits = QNAN_BITS;
                        else if (nexp >= int'(EXP_ALL_ONES))
                            r.double_bits = INF_BITS;
                        else if (nexp < 1)
                        begin
                            // subnormal: shift counted from the raw sum
                            shift = int'(op.max_exponent) + PRE_SHIFT
                                    - ((op.max_exponent != 0) ? 1 : 0) - 32;
                            sum = (shift >= 0) ? (sum << shift) : (sum >> (-shift));
                            r.double_bits = {neg, 11'd0, sum[51:0]};
                        end
                        else
                        begin
                            // normalize on the leading one, truncate the rest
                            sum = (lead >= FRAC_W) ? (sum >> (lead - FRAC_W))
                                                   : (sum << (FRAC_W - lead));
                            r.double_bits = {neg, nexp[10:0], sum[51:0]};
                        end
                    end
                end
                default:
                    r = '0;
            endcase
            return r;
        endfunction

        function void note_input(codec_op_t op);
            expected_words.push_back(compute_codec_result(op));
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        task log_mismatch(string what);
            $display("mismatch: %s", what);
            mismatch_count++;
        endtask

        // compare one accepted result with the oldest prediction
        task check_result(codec_word_t got);
            codec_word_t want;
            if (expected_words.size() == 0)
            begin
                log_mismatch($sformatf("result with nothing expected: %h", got));
                return;
            end
            want = expected_words.pop_front();
            if (got.out_exponent !== want.out_exponent)
                log_mismatch($sformatf("out_exponent got %h want %h",
                                       got.out_exponent, want.out_exponent));
            if (got.out_mantissa !== want.out_mantissa)
                log_mismatch($sformatf("out_mantissa got %h want %h",
                                       got.out_mantissa, want.out_mantissa));
            if (got.aligned_hi !== want.aligned_hi)
                log_mismatch($sformatf("aligned_hi got %h want %h",
                                       got.aligned_hi, want.aligned_hi));
            if (got.aligned_lo !== want.aligned_lo)
                log_mismatch($sformatf("aligned_lo got %h want %h",
                                       got.aligned_lo, want.aligned_lo));
            if (got.double_bits !== want.double_bits)
                log_mismatch($sformatf("double_bits got %h want %h",
                                       got.double_bits, want.double_bits));
        endtask
    endclass

endpackage

`default_nettype wire

FILE: tb/tb_fp64_block_float_codec_unit.sv
// tb_fp64_block_float_codec_unit: directed and random items through the codec,
// random idling on both channels, long output hold-off and a full drain
// depends on fbf_pkg, fbf_if, fbf_codec_check_pkg and the codec rtl
`default_nettype none

module tb_fp64_block_float_codec_unit;

    import fbf_pkg::*;
    import fbf_codec_check_pkg::*;

    localparam int RANDOM_ITEMS = 1650;
    localparam int RUN_LIMIT    = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n;

    bit req_idling = 1'b1;
    bit rsp_idling = 1'b1;
    int hold_off_cycles = 0;
    int cycle_count = 0;

    codec_result_book book = new();

    fbf_req_if request_bus ();
    fbf_rsp_if response_bus ();

    fp64_block_float_codec_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_bus),
        .response (response_bus)
    );

    always #6 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic codec_op_t split_op(logic [63:0] v);
        codec_op_t op;
        op = '0;
        op.action = ACT_SPLIT;
        op.value_bits = v;
        return op;
    endfunction

    function automatic codec_op_t align_op(int own, int mx, logic [53:0] m);
        codec_op_t op;
        op = '0;
        op.action = ACT_ALIGN;
        op.exponent = own[10:0];
        op.max_exponent = mx[10:0];
        op.split_mantissa = m;
        return op;
    endfunction

    function automatic codec_op_t regen_op(logic [31:0] hi, logic [63:0] lo, int mx);
        codec_op_t op;
        op = '0;
        op.action = ACT_REGEN;
        op.sum_hi = hi;
        op.sum_lo = lo;
        op.max_exponent = mx[10:0];
        return op;
    endfunction

    // random item, mostly shaped so that every branch of each action is reached
    function automatic codec_op_t draw_op();
        codec_op_t   op;
        logic [63:0] r;
        logic [95:0] mag;
        int          pick;
        int          d;
        int          mx;
        op.value_bits = rand64();
        op.exponent = 11'($urandom_range(0, 2047));
        op.max_exponent = 11'($urandom_range(0, 2047));
        r = rand64();
        op.split_mantissa = r[53:0];
        op.sum_hi = $urandom;
        op.sum_lo = rand64();
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            op.action = ACT_SPLIT;
            case ($urandom_range(0, 7))
                0: op.value_bits[62:52] = '0;
                1: op.value_bits[62:52] = EXP_ALL_ONES;
                default: ;
            endcase
        end
        else if (pick < 60)
        begin
            op.action = ACT_ALIGN;
            // keep the shift count mostly inside the word, edges included
            d = int'($urandom_range(0, 99)) - 2;
            mx = int'(op.exponent) + d - PRE_SHIFT;
            if (mx >= 0 && mx <= 2047 && $urandom_range(0, 9) != 0)
                op.max_exponent = mx[10:0];
            case ($urandom_range(0, 15))
                0: op.split_mantissa = {1'b1, 53'd0};
                1: op.split_mantissa = {1'b0, {53{1'b1}}};
                2: op.split_mantissa = '0;
                3: op.split_mantissa = '1;
                default: ;
            endcase
        end
        else if (pick < 95)
        begin
            op.action = ACT_REGEN;
            // random magnitude with a random leading-one position and sign
            mag = {$urandom, $urandom, $urandom};
            mag = mag >> $urandom_range(0, 95);
            if ($urandom_range(0, 1) != 0)
                mag = -mag;
            case ($urandom_range(0, 19))
                0: mag = '0;
                1: mag = {1'b1, 95'd0};
                2: mag = {op.sum_hi, op.sum_lo};
                default: ;
            endcase
            {op.sum_hi, op.sum_lo} = mag;
            case ($urandom_range(0, 9))
                0, 1, 2: op.max_exponent = 11'($urandom_range(0, 90));
                3:       op.max_exponent = '0;
                4, 5:    op.max_exponent = 11'($urandom_range(1960, 2046));
                6:       op.max_exponent = EXP_ALL_ONES;
                default: ;
            endcase
        end
        else
            op.action = ACT_NONE;
        return op;
    endfunction

    // offer one item and wait until it is taken
    task automatic offer_op(input codec_op_t op);
        int gap;
        gap = req_idling ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            request_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_bus.valid <= 1'b1;
        request_bus.action <= op.action;
        request_bus.value_bits <= op.value_bits;
        request_bus.exponent <= op.exponent;
        request_bus.max_exponent <= op.max_exponent;
        request_bus.split_mantissa <= op.split_mantissa;
        request_bus.sum_hi <= op.sum_hi;
        request_bus.sum_lo <= op.sum_lo;
        do
            @(posedge clk);
        while (request_bus.ready !== 1'b1);
        book.note_input(op);
    endtask

    task automatic wait_all_results();
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    // result side: random stalls, the long hold-off, and checking
    initial
    begin : result_side
        int          stall;
        codec_word_t got;
        response_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else
                stall = rsp_idling ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                response_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            response_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (response_bus.valid !== 1'b1);
            got.out_exponent = response_bus.out_exponent;
            got.out_mantissa = response_bus.out_mantissa;
            got.aligned_hi = response_bus.aligned_hi;
            got.aligned_lo = response_bus.aligned_lo;
            got.double_bits = response_bus.double_bits;
            book.check_result(got);
        end
    end

    // run limit
    initial
    begin : watchdog
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("fp64_block_float_codec_unit test failed");
        $finish;
    end

    // stimulus and end of run
    initial
    begin : item_source
        codec_op_t op;
        rst_n <= 1'b0;
        request_bus.valid <= 1'b0;
        request_bus.action <= ACT_SPLIT;
        request_bus.value_bits <= '0;
        request_bus.exponent <= '0;
        request_bus.max_exponent <= '0;
        request_bus.split_mantissa <= '0;
        request_bus.sum_hi <= '0;
        request_bus.sum_lo <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // split: zeros, normal, extreme, subnormal, infinity and nan patterns
        offer_op(split_op(64'h0000_0000_0000_0000));
        offer_op(split_op(64'h8000_0000_0000_0000));
        offer_op(split_op(64'h3FF0_0000_0000_0000));
        offer_op(split_op(64'hFFEF_FFFF_FFFF_FFFF));
        offer_op(split_op(64'h8000_0000_0000_0001));
        offer_op(split_op(64'h7FF0_0000_0000_0000));
        offer_op(split_op(64'hFFF8_0000_0000_0001));
        // align: no shift, deepest shift, shifts out of range, sign fill
        offer_op(align_op(100, 94, {1'b0, {53{1'b1}}}));
        offer_op(align_op(0, 89, {1'b1, 53'd0}));
        offer_op(align_op(0, 90, '1));
        offer_op(align_op(7, 0, 54'd12345));
        offer_op(align_op(0, 2047, {1'b1, 53'd0}));
        offer_op(align_op(10, 44, '1));
        // regenerate: zero, nan, overflow, most negative, subnormal, normal
        offer_op(regen_op(32'h0, 64'h0, 500));
        offer_op(regen_op(32'h0, 64'h0, 2047));
        offer_op(regen_op(32'h0, 64'h1, 2047));
        offer_op(regen_op(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 2047));
        offer_op(regen_op(32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 2040));
        offer_op(regen_op(32'h8000_0000, 64'h0, 1000));
        offer_op(regen_op(32'h0, 64'h0000_0000_0010_0000, 10));
        offer_op(regen_op(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_CFC7, 0));
        offer_op(regen_op(32'h0000_0001, rand64(), 1023));
        offer_op(regen_op(32'h0, 64'h5, 1100));
        op = draw_op();
        op.action = ACT_NONE;
        offer_op(op);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // change idling per stretch, some stretches run flat out
            if (n % 150 == 0)
            begin
                req_idling = ($urandom_range(0, 2) != 0);
                rsp_idling = ($urandom_range(0, 2) != 0);
            end
            // long output hold-off while items keep coming
            if (n == 400 || n == 1200)
            begin
                hold_off_cycles = HOLD_CYCLES;
                req_idling = 1'b0;
            end
            // pause input until every result is back
            if (n == 800)
            begin
                request_bus.valid <= 1'b0;
                wait_all_results();
            end
            offer_op(draw_op());
        end
        request_bus.valid <= 1'b0;

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.mismatch_count == 0 && book.pending() == 0)
            $display("fp64_block_float_codec_unit test passed");
        else
            $display("fp64_block_float_codec_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire
